// ===== rtl/waypoint_turn_speed_macros.svh =====
// Assertion macros for the waypoint turn speed block.
// Used by the top level only; assertions drop out when SYNTHESIS is set.
`ifndef WAYPOINT_TURN_SPEED_MACROS_SVH
`define WAYPOINT_TURN_SPEED_MACROS_SVH
`ifndef SYNTHESIS
`define WTS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define WTS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define WTS_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define WTS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/wts_pkg.sv =====
// Shared types, constants and the arctangent table for the waypoint turn speed block.
// No dependencies.
package wts_pkg;

    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SUM_W       = PROD_W;       // magnitudes of sums stay below 2^50
    localparam int SPEED_W     = 16;
    localparam int NORM_W      = 30;
    localparam int SH_W        = 5;
    localparam int CX_W        = NORM_W + 4;
    localparam int ANG_W       = 17;
    localparam int CORDIC_STEPS = 15;

    localparam logic [SUM_W-1:0] SEG_SQ_MIN = SUM_W'(1678);
    localparam int ANG_LOW  = 2560;
    localparam int ANG_HIGH = 12800;
    // floor(n / 5) as (n * RECIP5) >> RECIP5_SH, exact for n < 2^19
    localparam logic [18:0] RECIP5   = 19'd419431;
    localparam int          RECIP5_SH = 21;

    localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 16'd512;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd1024;

    localparam logic REG_MIN_SPEED = 1'b0;
    localparam logic REG_MAX_SPEED = 1'b1;

    typedef enum logic [1:0] {
        RES_CALC = 2'd0,
        RES_MIN  = 2'd1,
        RES_MAX  = 2'd2
    } res_code_t;

    function automatic logic signed [ANG_W-1:0] atan_at(input int i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0:  r = 17'sd11520;
            1:  r = 17'sd6801;
            2:  r = 17'sd3593;
            3:  r = 17'sd1824;
            4:  r = 17'sd916;
            5:  r = 17'sd458;
            6:  r = 17'sd229;
            7:  r = 17'sd115;
            8:  r = 17'sd57;
            9:  r = 17'sd29;
            10: r = 17'sd14;
            11: r = 17'sd7;
            12: r = 17'sd4;
            13: r = 17'sd2;
            default: r = 17'sd1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/waypoint_turn_speed.sv =====
// Target speed at a waypoint from the turn angle of three path points.
// Segment differences, products, sums, normalization, CORDIC arctangent, interpolation.
// Depends on wts_pkg and waypoint_turn_speed_macros.svh.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one point triple per item; m_tvalid/m_tready/
//   m_tdata carry the speed for it, one result item per input item, in order.
//   cfg_we/cfg_addr/cfg_wdata write the slowest speed (index 0) and the fastest
//   speed (index 1); write them only while no item is in flight.
//   Pipeline: 23 register stages (5 arithmetic stages, 15 CORDIC stages of one
//   rotation each, 2 interpolation stages, output register).
//   Throughput: one item per cycle while the receiver keeps taking results; each
//   stage is a register with its own valid bit and the per-stage ready chain lets
//   any empty stage fill.
//   When the receiver stalls, the output register holds its item and the stages
//   behind it keep filling until the pipeline is full; then s_tready falls.
//   Reset clears all valid bits and loads a slowest speed of 512 and a fastest
//   speed of 1024.
`include "waypoint_turn_speed_macros.svh"
module waypoint_turn_speed
    import wts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // prev_x, prev_y, cur_x, cur_y, next_x, next_y (24 bits each, low to high)
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // speed
    output logic [15:0]  m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    localparam int NST     = 23;
    localparam int ST_SUM  = 2;
    localparam int ST_ENC  = 3;
    localparam int ST_NORM = 4;
    localparam int ST_CRD  = 5;
    localparam int ST_INT  = ST_CRD + CORDIC_STEPS;
    localparam int ST_DIV  = ST_INT + 1;
    localparam int ST_OUT  = ST_DIV + 1;

    logic [SPEED_W-1:0] min_reg, max_reg;
    logic [NST-1:0]     v_reg;
    logic [NST-1:0]     en;
    res_code_t          code_reg  [NST];
    res_code_t          code_next [NST];

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_SPEED_RST;
            max_reg <= MAX_SPEED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MIN_SPEED: min_reg <= cfg_wdata;
                REG_MAX_SPEED: max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-stage advance: a stage loads when empty or when the next one loads
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // stage 0: segment differences
    logic signed [DIFF_W-1:0] px_reg, py_reg, qx_reg, qy_reg;
    logic signed [COORD_W-1:0] in_px, in_py, in_cx, in_cy, in_nx, in_ny;

    assign in_px = s_tdata[23:0];
    assign in_py = s_tdata[47:24];
    assign in_cx = s_tdata[71:48];
    assign in_cy = s_tdata[95:72];
    assign in_nx = s_tdata[119:96];
    assign in_ny = s_tdata[143:120];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg <= DIFF_W'(in_cx) - DIFF_W'(in_px);
            py_reg <= DIFF_W'(in_cy) - DIFF_W'(in_py);
            qx_reg <= DIFF_W'(in_nx) - DIFF_W'(in_cx);
            qy_reg <= DIFF_W'(in_ny) - DIFF_W'(in_cy);
        end
    end

    // stage 1: products
    logic signed [PROD_W-1:0] pxx_reg, pyy_reg, qxx_reg, qyy_reg;
    logic signed [PROD_W-1:0] pxqx_reg, pyqy_reg, pxqy_reg, pyqx_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pxx_reg  <= px_reg * px_reg;
            pyy_reg  <= py_reg * py_reg;
            qxx_reg  <= qx_reg * qx_reg;
            qyy_reg  <= qy_reg * qy_reg;
            pxqx_reg <= px_reg * qx_reg;
            pyqy_reg <= py_reg * qy_reg;
            pxqy_reg <= px_reg * qy_reg;
            pyqx_reg <= py_reg * qx_reg;
        end
    end

    // stage 2: squared lengths, dot, |cross| and early decisions
    logic [SUM_W-1:0]         pn, qn, crs_abs;
    logic signed [SUM_W:0]    dot_s, crs_s;
    logic [SUM_W-1:0]         dot2_reg, crs2_reg;

    always_comb
    begin
        pn      = SUM_W'(pxx_reg) + SUM_W'(pyy_reg);
        qn      = SUM_W'(qxx_reg) + SUM_W'(qyy_reg);
        dot_s   = (SUM_W+1)'(pxqx_reg) + (SUM_W+1)'(pyqy_reg);
        crs_s   = (SUM_W+1)'(pxqy_reg) - (SUM_W+1)'(pyqx_reg);
        crs_abs = crs_s[SUM_W] ? SUM_W'(-crs_s) : SUM_W'(crs_s);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            dot2_reg <= SUM_W'(dot_s);
            crs2_reg <= crs_abs;
        end
    end

    // stage 3: shift count so that both fit in NORM_W bits
    logic [SUM_W-1:0] dor;
    logic [SH_W-1:0]  sh;
    logic [SUM_W-1:0] dot3_reg, crs3_reg;
    logic [SH_W-1:0]  sh_reg;

    always_comb
    begin
        dor = dot2_reg | crs2_reg;
        sh  = '0;
        for (int b = NORM_W; b < SUM_W; b++)
            if (dor[b])
                sh = SH_W'(b - NORM_W + 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_ENC])
        begin
            dot3_reg <= dot2_reg;
            crs3_reg <= crs2_reg;
            sh_reg   <= sh;
        end
    end

    // stage 4 and CORDIC stages
    logic signed [CX_W-1:0]  cx_reg [CORDIC_STEPS+1];
    logic signed [CX_W-1:0]  cy_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] cz_reg [CORDIC_STEPS+1];
    logic [SUM_W-1:0]        dot_sh, crs_sh;

    assign dot_sh = dot3_reg >> sh_reg;
    assign crs_sh = crs3_reg >> sh_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_NORM])
        begin
            cx_reg[0] <= CX_W'(dot_sh[NORM_W-1:0]);
            cy_reg[0] <= CX_W'(crs_sh[NORM_W-1:0]);
            cz_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [ANG_W-1:0] ANG = atan_at(i);
        logic signed [CX_W-1:0] xs, ys;

        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en[ST_CRD+i])
            begin
                if (!cy_reg[i][CX_W-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] + ys;
                    cy_reg[i+1] <= cy_reg[i] - xs;
                    cz_reg[i+1] <= cz_reg[i] + ANG;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - ys;
                    cy_reg[i+1] <= cy_reg[i] + xs;
                    cz_reg[i+1] <= cz_reg[i] - ANG;
                end
            end
        end
    end

    // interpolation stage: (a - low) * (max - min)
    logic signed [ANG_W-1:0] ang;
    logic [13:0]             dang;
    logic signed [ANG_W-1:0] span;
    logic signed [31:0]      prod_reg;

    always_comb
    begin
        ang  = cz_reg[CORDIC_STEPS][ANG_W-1] ? '0 : cz_reg[CORDIC_STEPS];
        dang = 14'(ang - ANG_W'(ANG_LOW));
        span = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_INT])
            prod_reg <= $signed(32'({1'b0, dang})) * 32'(span);
    end

    // divide by 10240 toward zero: magnitude >> 11, then by 5 through a reciprocal
    logic [30:0] mag;
    logic [19:0] mag_hi;
    logic [38:0] rq;
    logic [SPEED_W-1:0] q_reg;
    logic               neg_reg;

    always_comb
    begin
        mag    = prod_reg[31] ? 31'(-prod_reg) : 31'(prod_reg);
        mag_hi = mag[30:11];
        rq     = 39'(mag_hi) * 39'(RECIP5);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV])
        begin
            q_reg   <= SPEED_W'(rq >> RECIP5_SH);
            neg_reg <= prod_reg[31];
        end
    end

    // result codes travel with the data
    always_comb
    begin
        code_next[0] = RES_CALC;
        for (int k = 1; k < NST; k++)
            code_next[k] = code_reg[k-1];
        if (pn < SEG_SQ_MIN || qn < SEG_SQ_MIN || dot_s[SUM_W] || dot_s == '0)
            code_next[ST_SUM] = RES_MIN;
        else if (crs_abs == '0)
            code_next[ST_SUM] = RES_MAX;
        else
            code_next[ST_SUM] = RES_CALC;
        if (code_reg[ST_INT-1] == RES_CALC)
        begin
            if (ang < ANG_W'(ANG_LOW))
                code_next[ST_INT] = RES_MAX;
            else if (ang > ANG_W'(ANG_HIGH))
                code_next[ST_INT] = RES_MIN;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
            if (en[k])
                code_reg[k] <= code_next[k];
    end

    // output register
    logic [SPEED_W-1:0] speed_reg, speed_next;

    always_comb
    begin
        case (code_reg[ST_DIV])
            RES_MIN: speed_next = min_reg;
            RES_MAX: speed_next = max_reg;
            default: speed_next = neg_reg ? min_reg - q_reg : min_reg + q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
            speed_reg <= speed_next;
    end

    assign m_tvalid = v_reg[ST_OUT];
    assign m_tdata  = speed_reg;

    logic [SPEED_W-1:0] lo_bound, hi_bound;
    logic               norm_top_zero;

    assign lo_bound      = (min_reg <= max_reg) ? min_reg : max_reg;
    assign hi_bound      = (min_reg <= max_reg) ? max_reg : min_reg;
    assign norm_top_zero = cx_reg[0][CX_W-1:NORM_W] == '0 && cy_reg[0][CX_W-1:NORM_W] == '0;

    `WTS_ASSERT_NOW(a_ready_when_empty_out, clk, rst_n, !m_tvalid, s_tready)
    `WTS_ASSERT_NOW(a_speed_in_range, clk, rst_n, m_tvalid, (m_tdata >= lo_bound && m_tdata <= hi_bound))
    `WTS_ASSERT_NOW(a_norm_fits, clk, rst_n, v_reg[ST_NORM] && code_reg[ST_NORM] == RES_CALC, norm_top_zero)

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for waypoint_turn_speed: random and directed point triples, checked
// against a built-in speed predictor with a scoreboard class.
// Depends on wts_pkg and the waypoint_turn_speed RTL.
`timescale 1ns / 100ps

module testbench;
    import wts_pkg::*;

    localparam int PIPE_LAT = 23;
    localparam int N_RANDOM = 1950;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_addr = REG_MIN_SPEED;
    logic [15:0]  cfg_wdata = '0;

    bit hold_off = 1'b0;
    int n_sent = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    waypoint_turn_speed u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    class speed_scoreboard;
        logic [15:0] min_spd = MIN_SPEED_RST;
        logic [15:0] max_spd = MAX_SPEED_RST;
        logic [15:0] pending_speeds[$];
        int n_bad = 0;
        int n_checked = 0;
        int n_short = 0;
        int n_blend = 0;

        function logic [15:0] predict_speed(logic [143:0] pts);
            longint px, py, qx, qy, pn, qn, dt, cr, x, y, z, xs, ys, lo, hi;
            px = longint'($signed(pts[71:48])) - longint'($signed(pts[23:0]));
            py = longint'($signed(pts[95:72])) - longint'($signed(pts[47:24]));
            qx = longint'($signed(pts[119:96])) - longint'($signed(pts[71:48]));
            qy = longint'($signed(pts[143:120])) - longint'($signed(pts[95:72]));
            pn = px * px + py * py;
            qn = qx * qx + qy * qy;
            lo = min_spd;
            hi = max_spd;
            if (pn < 1678 || qn < 1678)
            begin
                n_short++;
                return min_spd;
            end
            dt = px * qx + py * qy;
            cr = px * qy - py * qx;
            if (cr < 0)
                cr = -cr;
            if (dt <= 0)
                return min_spd;
            if (cr == 0)
                return max_spd;
            while (((dt | cr) >>> 30) != 0)
            begin
                dt = dt >>> 1;
                cr = cr >>> 1;
            end
            x = dt;
            y = cr;
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z += longint'(atan_at(i));
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z -= longint'(atan_at(i));
                end
            end
            if (z < 0)
                z = 0;
            if (z < ANG_LOW)
                return max_spd;
            if (z > ANG_HIGH)
                return min_spd;
            n_blend++;
            return 16'(lo + ((z - ANG_LOW) * (hi - lo)) / 10240);
        endfunction

        function void note_input(logic [143:0] pts);
            pending_speeds.insert(pending_speeds.size(), predict_speed(pts));
        endfunction

        function void check_result(logic [15:0] got);
            logic [15:0] want;
            n_checked++;
            if (pending_speeds.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result item: speed %0d", got);
                return;
            end
            want = pending_speeds.pop_front();
            if (got !== want)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("speed mismatch: expected %0d actual %0d", want, got);
            end
        endfunction
    endclass

    speed_scoreboard sb = new();

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_input(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // receiver stalls on its own pattern, with quiet stretches and a long hold-off
    initial
    begin
        int phase;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (hold_off)
                m_tready <= 1'b0;
            else if ((phase / 300) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MIN_SPEED)
            sb.min_spd = val;
        else
            sb.max_spd = val;
    endtask

    task automatic drain();
        while (sb.pending_speeds.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // offer one item and hold it until taken; valid stays high for back-to-back items
    task automatic send_points(logic [143:0] pts);
        s_tvalid <= 1'b1;
        s_tdata <= pts;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [143:0] pack_pts(int ax, int ay, int bx, int by, int cx, int cy);
        return {24'(cy), 24'(cx), 24'(by), 24'(bx), 24'(ay), 24'(ax)};
    endfunction

    // mostly a plausible path with random turn; sometimes raw noise or short legs
    function automatic logic [143:0] random_points();
        int bx, by, ax, ay, cx, cy, r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        bx = $signed($urandom) >>> 9;
        by = $signed($urandom) >>> 9;
        r = $urandom_range(0, 9) == 0 ? 60 : (1 << $urandom_range(6, 20));
        ax = bx - $signed($urandom_range(0, 2 * r)) + r;
        ay = by - $signed($urandom_range(0, 2 * r)) + r;
        cx = bx + (bx - ax) + $signed($urandom_range(0, r)) - r / 2;
        cy = by + (by - ay) + $signed($urandom_range(0, r)) - r / 2;
        return pack_pts(ax, ay, bx, by, cx, cy);
    endfunction

    task automatic run_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            send_points(random_points());
            idle_gap();
        end
        s_tvalid <= 1'b0;
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: short legs, straight, reverse, right angle, blend band, extremes
        send_points(pack_pts(0, 0, 40, 0, 80, 0));
        send_points(pack_pts(0, 0, 41, 0, 82, 0));
        send_points(pack_pts(0, 0, 4096, 0, 8192, 0));
        send_points(pack_pts(0, 0, 4096, 0, 0, 0));
        send_points(pack_pts(0, 0, 4096, 0, 4096, 4096));
        send_points(pack_pts(0, 0, 4096, 0, 8192, 1500));
        send_points(pack_pts(0, 0, 4096, 0, 8192, 700));
        send_points(pack_pts(0, 0, 4096, 0, 8192, 3000));
        send_points(pack_pts(0, 0, 4096, 0, 8192, 4500));
        send_points(pack_pts(0, 0, 4096, 0, 8192, 100));
        send_points(pack_pts(-8388608, -8388608, 0, 0, 8388607, 8388607));
        send_points(pack_pts(8388607, -8388608, -8388608, 8388607, 8388607, -8388608));
        send_points(pack_pts(-8388608, 0, 8388607, 0, 8388607, 8388607));
        send_points({144{1'b1}});
        send_points('0);
        send_points(pack_pts(0, 0, 29, 29, 58, 58));
        s_tvalid <= 1'b0;
        drain();

        // swapped extremes, then the long receiver hold-off with the sender still offering
        write_reg(REG_MIN_SPEED, 16'hFFFF);
        write_reg(REG_MAX_SPEED, 16'h0000);
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            run_phase(300);
        join

        write_reg(REG_MIN_SPEED, 16'h0000);
        write_reg(REG_MAX_SPEED, 16'hFFFF);
        run_phase(500);
        write_reg(REG_MIN_SPEED, 16'd777);
        write_reg(REG_MAX_SPEED, 16'd777);
        run_phase(200);
        write_reg(REG_MIN_SPEED, 16'd300);
        write_reg(REG_MAX_SPEED, 16'd40000);
        run_phase(N_RANDOM - 1000);

        $display("sent %0d point triples over five speed settings; %0d short-leg, %0d blended",
                 n_sent, sb.n_short, sb.n_blend);
        $display("checked %0d speeds, %0d mismatches", sb.n_checked, sb.n_bad);
        if (sb.n_bad == 0 && sb.pending_speeds.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
